[sv/tmap_pkg.sv]
// ----------------------------------------------------------------------------
// tmap_pkg
// Types, widths and codes shared by the tempo map modules.
// ----------------------------------------------------------------------------
package tmap_pkg;

    localparam int MAX_CHANGES = 64;
    localparam int IDX_W       = $clog2(MAX_CHANGES);
    localparam int CNT_W       = $clog2(MAX_CHANGES + 1);

    localparam int TICK_W   = 32;
    localparam int TEMPO_W  = 24;
    localparam int TPQ_W    = 15;
    localparam int MS_W     = 32;
    localparam int STAT_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // divisor is tpq * 1000, product is tempo * delta, plus half the divisor
    localparam int DVSR_W   = 25;
    localparam int PROD_W   = TEMPO_W + TICK_W;
    localparam int DVD_W    = PROD_W + 1;
    localparam int DCNT_W   = $clog2(DVD_W + 1);

    localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = TEMPO_W'(500000);
    localparam logic [DVSR_W-1:0]  MS_SCALE      = DVSR_W'(1000);
    localparam logic [TPQ_W-1:0]   TPQ_RESET     = TPQ_W'(96);

    localparam logic [PADDR_W-1:0] ADDR_TPQ = PADDR_W'(0);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_CONV = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UPD  = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [TICK_W-1:0]  tick;
        logic [TEMPO_W-1:0] tempo;
    } t_in_word;

    typedef struct packed {
        logic [MS_W-1:0]   millis;
        logic [STAT_W-1:0] status;
    } t_out_word;

    typedef struct packed {
        logic [TICK_W-1:0]  tick;
        logic [TEMPO_W-1:0] tempo;
    } t_entry;

    typedef struct packed {
        logic               valid;
        logic               conv;
        logic [TICK_W-1:0]  tick;
        logic [TEMPO_W-1:0] tempo;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARD,
        ST_ACMP,
        ST_ACHK,
        ST_SRD,
        ST_SWR,
        ST_CRD,
        ST_CCHK,
        ST_CMUL,
        ST_CDIV,
        ST_CACC,
        ST_DONE
    } t_state;

endpackage

[sv/tempo_map_tick_to_ms.sv]
// ----------------------------------------------------------------------------
// tempo_map_tick_to_ms
// Tempo map: sorted table of tempo changes, converts ticks to milliseconds.
//
//   channel   direction  handshake                     payload
//   in        input      i_in_valid / o_in_stall       i_in_word (cmd, tick, tempo)
//   out       output     o_out_valid / i_out_stall     o_out_word (millis, status)
//   config    input      apb psel/penable/pwrite       paddr, pwdata, prdata
//
// add word: the table is scanned down from the top, a read and a compare per entry,
// then each entry above the insertion point is moved up, a read and a write per entry.
// convert word: one segment per entry at or below the tick, plus one, each
// divided by the one-bit-per-cycle divider.
// synchronous active-low reset empties the table; no clearing pass.
// a two-word input queue keeps taking words, until it is full, while the result register stalls.
// ----------------------------------------------------------------------------
module tempo_map_tick_to_ms (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tmap_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tmap_pkg::t_out_word               o_out_word,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmap_pkg::PADDR_W-1:0]      paddr,
    input  logic [tmap_pkg::PDATA_W-1:0]      pwdata,
    output logic [tmap_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import tmap_pkg::*;

    logic [TPQ_W-1:0] r_tpq;
    t_job             job;
    logic             pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TPQ) ? PDATA_W'(r_tpq) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpq <= TPQ_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_TPQ) begin
            r_tpq <= pwdata[TPQ_W-1:0];
        end
    end

    tmap_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_job      (job),
        .i_pop      (pop)
    );

    tmap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .o_pop       (pop),
        .i_tpq       (r_tpq),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

[sv/tmap_front.sv]
// ----------------------------------------------------------------------------
// tmap_front
// Input side: two-deep word queue that tags each word as add or convert.
// ----------------------------------------------------------------------------
module tmap_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tmap_pkg::t_in_word i_in_word,
    output tmap_pkg::t_job    o_job,
    input  logic              i_pop
);
    import tmap_pkg::*;

    t_in_word   r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_in_word   head;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_cnt != 2'd0);
    assign head       = r_q[r_rp];

    assign o_job.valid = (r_cnt != 2'd0);
    assign o_job.conv  = (head.cmd == CMD_CONV);
    assign o_job.tick  = head.tick;
    assign o_job.tempo = head.tempo;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue occupancy out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !push) |=> (r_cnt == 2'd0))
        else $error("queue lost track of empty state");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> o_in_stall)
        else $error("full queue stopped stalling");

endmodule

[sv/tmap_back.sv]
// ----------------------------------------------------------------------------
// tmap_back
// Execution side: sorted change table, insert/update walk, segment walk with
// a bit-serial divider, and the result register.
// ----------------------------------------------------------------------------
module tmap_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tmap_pkg::t_job                i_job,
    output logic                          o_pop,
    input  logic [tmap_pkg::TPQ_W-1:0]    i_tpq,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tmap_pkg::t_out_word           o_out_word
);
    import tmap_pkg::*;

    t_entry r_mem [MAX_CHANGES];
    t_entry r_rdata;

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_pos, n_pos;
    t_job               r_job, n_job;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [MS_W-1:0]    r_sum, n_sum;
    logic [TICK_W-1:0]  r_prev, n_prev;
    logic [TEMPO_W-1:0] r_cur, n_cur;
    logic               r_last, n_last;
    logic [TEMPO_W-1:0] r_mul_a, n_mul_a;
    logic [TICK_W-1:0]  r_mul_b, n_mul_b;
    logic [DVD_W-1:0]   r_dvd, n_dvd;
    logic [DVSR_W-1:0]  r_rem, n_rem;
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic [DVSR_W-1:0]  r_dvsr, n_dvsr;
    logic               r_ovld, n_ovld;
    t_out_word          r_out, n_out;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    logic [CNT_W-1:0]   k_dec;
    logic [DVSR_W:0]    rem_sh;
    logic [DVSR_W+1:0]  diff;
    logic [MS_W-1:0]    seg;
    logic               out_free;

    assign k_dec    = r_k - CNT_W'(1);
    assign rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, r_dvsr};
    // segment saturates when the quotient does not fit in 31 bits
    assign seg      = (|r_dvd[DVD_W-1:MS_W-1]) ? '1 : r_dvd[MS_W-1:0];
    assign out_free = !r_ovld || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job.valid) begin
                    n_state = i_job.conv ? ST_CRD : ST_ARD;
                end
            end
            ST_ARD: begin
                n_state = (r_k == '0) ? ST_ACHK : ST_ACMP;
            end
            ST_ACMP: begin
                if (r_rdata.tick > r_job.tick) begin
                    n_state = ST_ARD;
                end else if (r_rdata.tick == r_job.tick) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ACHK;
                end
            end
            ST_ACHK: begin
                n_state = (r_count >= CNT_W'(MAX_CHANGES)) ? ST_DONE : ST_SRD;
            end
            ST_SRD: begin
                n_state = (r_k == r_pos) ? ST_DONE : ST_SWR;
            end
            ST_SWR:  n_state = ST_SRD;
            ST_CRD:  n_state = ST_CCHK;
            ST_CCHK: n_state = ST_CMUL;
            ST_CMUL: n_state = ST_CDIV;
            ST_CDIV: begin
                if (r_dcnt == DCNT_W'(DVD_W - 1)) begin
                    n_state = ST_CACC;
                end
            end
            ST_CACC: begin
                n_state = r_last ? ST_DONE : ST_CRD;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count   = r_count;
        n_k       = r_k;
        n_pos     = r_pos;
        n_job     = r_job;
        n_status  = r_status;
        n_sum     = r_sum;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_last    = r_last;
        n_mul_a   = r_mul_a;
        n_mul_b   = r_mul_b;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_dvsr    = r_dvsr;
        n_out     = r_out;
        n_ovld    = r_ovld && i_out_stall;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = k_dec[IDX_W-1:0];
        mem_wdata = r_rdata;
        mem_raddr = k_dec[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_job.valid) begin
                    o_pop    = 1'b1;
                    n_job    = i_job;
                    n_dvsr   = DVSR_W'(i_tpq) * MS_SCALE;
                    n_status = STAT_OK;
                    n_sum    = '0;
                    n_prev   = '0;
                    n_cur    = DEFAULT_TEMPO;
                    n_k      = i_job.conv ? '0 : r_count;
                end
            end
            ST_ARD: begin
                if (r_k == '0) begin
                    n_pos = '0;
                end
            end
            ST_ACMP: begin
                if (r_rdata.tick > r_job.tick) begin
                    n_k = k_dec;
                end else if (r_rdata.tick == r_job.tick) begin
                    mem_we          = 1'b1;
                    mem_wdata.tick  = r_rdata.tick;
                    mem_wdata.tempo = r_job.tempo;
                    n_status        = STAT_UPD;
                end else begin
                    n_pos = r_k;
                end
            end
            ST_ACHK: begin
                if (r_count >= CNT_W'(MAX_CHANGES)) begin
                    n_status = STAT_FULL;
                end else begin
                    n_k = r_count;
                end
            end
            ST_SRD: begin
                if (r_k == r_pos) begin
                    mem_we          = 1'b1;
                    mem_waddr       = r_pos[IDX_W-1:0];
                    mem_wdata.tick  = r_job.tick;
                    mem_wdata.tempo = r_job.tempo;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            ST_SWR: begin
                // move one entry up to open the insertion slot
                mem_we    = 1'b1;
                mem_waddr = r_k[IDX_W-1:0];
                n_k       = k_dec;
            end
            ST_CRD: begin
                mem_raddr = r_k[IDX_W-1:0];
            end
            ST_CCHK: begin
                n_mul_a = r_cur;
                if (r_k < r_count && r_rdata.tick <= r_job.tick) begin
                    n_mul_b = r_rdata.tick - r_prev;
                    n_cur   = r_rdata.tempo;
                    n_prev  = r_rdata.tick;
                    n_k     = r_k + CNT_W'(1);
                    n_last  = 1'b0;
                end else begin
                    n_mul_b = r_job.tick - r_prev;
                    n_last  = 1'b1;
                end
            end
            ST_CMUL: begin
                n_dvd  = DVD_W'(r_mul_a) * DVD_W'(r_mul_b) + DVD_W'(r_dvsr >> 1);
                n_rem  = '0;
                n_dcnt = '0;
            end
            ST_CDIV: begin
                if (!diff[DVSR_W+1]) begin
                    n_rem = diff[DVSR_W-1:0];
                end else begin
                    n_rem = rem_sh[DVSR_W-1:0];
                end
                n_dvd  = {r_dvd[DVD_W-2:0], !diff[DVSR_W+1]};
                n_dcnt = r_dcnt + DCNT_W'(1);
            end
            ST_CACC: begin
                n_sum = r_sum + seg;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovld        = 1'b1;
                    n_out.millis  = r_job.conv ? r_sum : '0;
                    n_out.status  = r_job.conv ? STAT_OK : r_status;
                end
            end
            default: begin
                n_ovld = r_ovld && i_out_stall;
            end
        endcase
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_pos   <= n_pos;
        r_job   <= n_job;
        r_status <= n_status;
        r_sum   <= n_sum;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_last  <= n_last;
        r_mul_a <= n_mul_a;
        r_mul_b <= n_mul_b;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_dvsr  <= n_dvsr;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovld  <= n_ovld;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CHANGES))
        else $error("entry count above table depth");

    a_count_only_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SRD) |=> $stable(r_count))
        else $error("entry count changed outside insertion");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CDIV) |-> (r_dcnt < DCNT_W'(DVD_W)))
        else $error("divider ran past its step count");

    a_no_write_in_convert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRD || r_state == ST_CCHK || r_state == ST_CDIV) |-> !mem_we)
        else $error("table written during a conversion");

endmodule

[tb/tempo_map_tick_to_ms_tb.sv]
// ----------------------------------------------------------------------------
// tempo_map_tick_to_ms_tb
// Self-checking bench for the tempo map. A class keeps its own copy of the
// sorted change table and divisor, works out the millis and status of every
// accepted word, and checks each result word in order. Directed words come
// first, then random phases over several time divisions, including zero.
// ----------------------------------------------------------------------------
module tempo_map_tick_to_ms_tb;
    import tmap_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int PHASE_WORDS = 258;

    class tempo_map_model;
        logic [TICK_W-1:0]  ticks  [MAX_CHANGES];
        logic [TEMPO_W-1:0] tempos [MAX_CHANGES];
        int                 count;
        logic [TPQ_W-1:0]   tpq;
        t_out_word          pending_ms[$];
        int                 errors;
        int                 mismatches;

        function new();
            count = 0;
            tpq = TPQ_RESET;
            errors = 0;
            mismatches = 0;
        endfunction

        function logic [31:0] segment(logic [31:0] tempo, logic [31:0] delta);
            logic [31:0] dv;
            logic [63:0] prod;
            logic [63:0] q;
            dv = 32'(tpq) * 32'd1000;
            if (dv == 0) return 32'hFFFF_FFFF;
            prod = 64'(tempo) * 64'(delta);
            q = (prod + 64'(dv / 2)) / 64'(dv);
            if (q > 64'h7FFF_FFFF) return 32'hFFFF_FFFF;
            return q[31:0];
        endfunction

        function logic [STAT_W-1:0] insert(logic [TICK_W-1:0] tick, logic [TEMPO_W-1:0] tempo);
            int idx;
            idx = count;
            while (idx > 0 && ticks[idx-1] > tick) idx--;
            if (idx > 0 && ticks[idx-1] == tick) begin
                tempos[idx-1] = tempo;
                return STAT_UPD;
            end
            if (count >= MAX_CHANGES) return STAT_FULL;
            for (int k = count; k > idx; k--) begin
                ticks[k] = ticks[k-1];
                tempos[k] = tempos[k-1];
            end
            ticks[idx] = tick;
            tempos[idx] = tempo;
            count++;
            return STAT_OK;
        endfunction

        function logic [MS_W-1:0] convert(logic [TICK_W-1:0] query);
            logic [31:0] sum;
            logic [31:0] prev;
            logic [31:0] cur;
            int i;
            sum = 0;
            prev = 0;
            cur = 32'(DEFAULT_TEMPO);
            i = 0;
            while (i < count && ticks[i] <= query) begin
                sum += segment(cur, ticks[i] - prev);
                cur = 32'(tempos[i]);
                prev = ticks[i];
                i++;
            end
            sum += segment(cur, query - prev);
            return sum;
        endfunction

        function void accept_word(t_in_word w);
            t_out_word r;
            if (w.cmd == CMD_ADD) begin
                r.millis = '0;
                r.status = insert(w.tick, w.tempo);
            end else begin
                r.millis = convert(w.tick);
                r.status = STAT_OK;
            end
            pending_ms.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (pending_ms.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result word millis=%h status=%0d",
                             got.millis, got.status);
                return;
            end
            exp_w = pending_ms.pop_front();
            if (got.millis !== exp_w.millis || got.status !== exp_w.status) begin
                errors++;
                if (mismatches++ < 10)
                    $display("mismatch: millis exp %h got %h, status exp %0d got %0d",
                             exp_w.millis, got.millis, exp_w.status, got.status);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_word            i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_word           o_out_word;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    tempo_map_model model;
    bit             steady;
    int             stall_left;
    int             idle_cycles;

    tempo_map_tick_to_ms u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result side: check accepted words, then draw a stall for the next one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            model.check_result(o_out_word);
            stall_left = steady ? 0 : $urandom_range(0, 4);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_word(t_in_word w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        model.accept_word(w);
    endtask

    task automatic send(logic cmd, logic [TICK_W-1:0] tick, logic [TEMPO_W-1:0] tempo);
        t_in_word w;
        w.cmd = cmd;
        w.tick = tick;
        w.tempo = tempo;
        push_word(w);
    endtask

    // hold off until every result has come back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (model.pending_ms.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_tpq(logic [TPQ_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TPQ;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        model.tpq = v;
    endtask

    task automatic random_word();
        logic [TICK_W-1:0]  tick;
        logic [TEMPO_W-1:0] tempo;
        int                 pick;
        pick = $urandom_range(0, 9);
        tempo = (pick < 3) ? TEMPO_W'($urandom_range(0, 2000000)) : TEMPO_W'($urandom);
        if ($urandom_range(0, 1) == 0) begin
            if (pick < 4 && model.count > 0)
                tick = model.ticks[$urandom_range(0, model.count - 1)];
            else if (pick < 7)
                tick = $urandom_range(0, 100000);
            else
                tick = $urandom;
            send(CMD_ADD, tick, tempo);
        end else begin
            // query on, just below or just above a change, else short or anywhere
            if (pick < 4 && model.count > 0)
                tick = model.ticks[$urandom_range(0, model.count - 1)]
                       + 32'($signed($urandom_range(0, 2)) - 1);
            else if (pick < 7)
                tick = $urandom_range(0, 2000);
            else
                tick = $urandom;
            send(CMD_CONV, tick, tempo);
        end
    endtask

    initial begin
        logic [TPQ_W-1:0] divisions[6];
        model = new();
        steady = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_tpq(TPQ_RESET);
        // empty table: zero, a rounding half, and an overflowing segment
        send(CMD_CONV, 32'd0, 24'hFFFFFF);
        send(CMD_CONV, 32'd12, 24'h000000);
        send(CMD_CONV, 32'hFFFF_FFFF, 24'h5A5A5A);
        send(CMD_ADD, 32'd100, 24'h000000);
        send(CMD_ADD, 32'd100, 24'hFFFFFF);
        send(CMD_ADD, 32'd0, 24'd123456);
        send(CMD_ADD, 32'hFFFF_FFFF, 24'hFFFFFF);
        send(CMD_ADD, 32'd12, 24'd250000);
        send(CMD_ADD, 32'd0, 24'd500000);
        send(CMD_CONV, 32'd0, 24'h000000);
        send(CMD_CONV, 32'd12, 24'h000000);
        send(CMD_CONV, 32'd99, 24'h000000);
        send(CMD_CONV, 32'd100, 24'h000000);
        send(CMD_CONV, 32'd101, 24'h000000);
        send(CMD_CONV, 32'hFFFF_FFFE, 24'h000000);
        send(CMD_CONV, 32'hFFFF_FFFF, 24'h000000);
        send(CMD_ADD, 32'h8000_0000, 24'd1);
        send(CMD_CONV, 32'h8000_0001, 24'hFFFFFF);
        drain();

        divisions[0] = TPQ_RESET;
        divisions[1] = 15'd1;
        divisions[2] = 15'd32767;
        divisions[3] = 15'd0;
        divisions[4] = TPQ_W'($urandom_range(1, 32767));
        divisions[5] = 15'd7;
        for (int ph = 0; ph < 6; ph++) begin
            write_tpq(divisions[ph]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // stretches with no gaps or stalls at all
                if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
                random_word();
            end
            steady = 1'b0;
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (model.errors == 0 && model.pending_ms.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
